/* design/tcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and codes shared by the time-tagged command scheduler modules.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_FULL        = 4'd1;
  localparam logic [3:0] ST_SUB_SCHED   = 4'd2;
  localparam logic [3:0] ST_COUNT       = 4'd3;
  localparam logic [3:0] ST_ILK_SET     = 4'd4;
  localparam logic [3:0] ST_ILK_ASSESS  = 4'd5;
  localparam logic [3:0] ST_ASSESS_TYPE = 4'd6;
  localparam logic [3:0] ST_TIME_TYPE   = 4'd7;
  localparam logic [3:0] ST_APP_ID      = 4'd8;

  localparam logic CFG_APP_ID_LIMIT    = 1'b0;
  localparam logic CFG_TIME_TYPE_LIMIT = 1'b1;

  localparam logic [7:0] APP_ID_LIMIT_RST    = 8'd255;
  localparam logic [7:0] TIME_TYPE_LIMIT_RST = 8'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] current_time;
    logic [7:0]  sub_schedule;
    logic [7:0]  tc_count;
    logic [7:0]  interlock_set;
    logic [7:0]  interlock_assess;
    logic [7:0]  assess_type;
    logic [7:0]  time_type;
    logic [31:0] due_time;
    logic [15:0] run_timeout;
    logic [7:0]  app_id;
    logic [13:0] seq_cnt;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [7:0]  out_app_id;
    logic [13:0] out_seq_cnt;
    logic [15:0] out_timeout;
    logic [4:0]  loaded_count;
    logic        full_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] rel_time;
    logic [7:0]  app;
    logic [13:0] seq;
    logic [15:0] timeout;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_CLEAR,
    S_TICK_RD,
    S_TICK_CMP
  } state_t;

  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic emit_ins;
    logic emit_rel;
    logic emit_done;
    logic clear_table;
  } tcs_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       at_end;
    logic       slot_free;
    logic       match;
    logic       out_free;
  } tcs_stat_t;

endpackage
`default_nettype wire

/* design/time_tagged_command_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// time_tagged_command_scheduler
// Table of commands that are released when a tick carries their release time.
// ----------------------------------------------------------------------------
// An insert finds the lowest free slot by stepping through the valid bits from
// slot zero. A tick reads each slot from the entry memory and then compares its
// time, followed by the done result. A result that is due while the previous
// result still waits at the output holds the sequence until the output is free.
// The valid bits are cleared at reset at once, so there is no clearing pass.
module time_tagged_command_scheduler import tcs_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  tcs_cmd_t  cmd;
  tcs_stat_t stat;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* design/tcs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer for insert scans, tick scans and table clears.
// ----------------------------------------------------------------------------
module tcs_ctrl import tcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tcs_stat_t stat,
  output tcs_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (stat.func)
            FUNC_INSERT: state_nxt = S_INS_SCAN;
            FUNC_TICK:   state_nxt = S_TICK_RD;
            FUNC_CLEAR:  state_nxt = S_CLEAR;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (stat.out_free && (stat.at_end || stat.slot_free)) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK_RD: begin
        if (!stat.at_end) begin
          state_nxt = S_TICK_CMP;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK_CMP: begin
        if (!stat.match || stat.out_free) begin
          state_nxt = S_TICK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.latch   = in_valid;
        cmd.idx_clr = in_valid;
      end
      S_INS_SCAN: begin
        cmd.emit_ins = stat.out_free && (stat.at_end || stat.slot_free);
        cmd.idx_inc  = !stat.at_end && !stat.slot_free;
      end
      S_CLEAR: begin
        cmd.clear_table = stat.out_free;
      end
      S_TICK_RD: begin
        cmd.rd_en     = !stat.at_end;
        cmd.emit_done = stat.at_end && stat.out_free;
      end
      S_TICK_CMP: begin
        cmd.emit_rel = stat.match && stat.out_free;
        cmd.idx_inc  = !stat.match || stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/tcs_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_dp
// Entry memory, valid bits, header checks, counters and the result register.
// ----------------------------------------------------------------------------
module tcs_dp import tcs_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire tcs_cmd_t  cmd,
  output tcs_stat_t      stat
);

  localparam int IDX_W  = $clog2(SLOTS + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  in_item_t          item_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [7:0]        app_lim_r, time_lim_r;
  entry_t            mem [SLOTS];
  entry_t            rd_r;
  entry_t            wr_entry;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [ADDR_W-1:0] addr;
  logic              at_end;
  logic              slot_free;
  logic [3:0]        ins_status;

  assign addr      = idx_r[ADDR_W-1:0];
  assign at_end    = (idx_r == IDX_W'(SLOTS));
  assign slot_free = !at_end && !valid_r[addr];

  always_comb begin
    if (at_end) begin
      ins_status = ST_FULL;
    end else if (item_r.sub_schedule != 8'd1) begin
      ins_status = ST_SUB_SCHED;
    end else if (item_r.tc_count != 8'd1) begin
      ins_status = ST_COUNT;
    end else if (item_r.interlock_set != 8'd0) begin
      ins_status = ST_ILK_SET;
    end else if (item_r.interlock_assess != 8'd0) begin
      ins_status = ST_ILK_ASSESS;
    end else if (item_r.assess_type != 8'd1) begin
      ins_status = ST_ASSESS_TYPE;
    end else if (item_r.time_type >= time_lim_r) begin
      ins_status = ST_TIME_TYPE;
    end else if (item_r.app_id >= app_lim_r) begin
      ins_status = ST_APP_ID;
    end else begin
      ins_status = ST_OK;
    end
  end

  assign stat.func      = in_data.func;
  assign stat.at_end    = at_end;
  assign stat.slot_free = slot_free;
  assign stat.match     = valid_r[addr] && (rd_r.rel_time == item_r.current_time);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign wr_entry.rel_time = item_r.due_time;
  assign wr_entry.app      = item_r.app_id;
  assign wr_entry.seq      = item_r.seq_cnt;
  assign wr_entry.timeout  = item_r.run_timeout;

  always_ff @(posedge clk) begin
    if (cmd.emit_ins && ins_status == ST_OK) begin
      mem[addr] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  always_comb begin
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_ins) begin
      if (ins_status == ST_OK) begin
        valid_nxt[addr] = 1'b1;
        cnt_nxt         = cnt_r + IDX_W'(1);
      end
      out_data_nxt        = '0;
      out_data_nxt.kind   = KIND_STATUS;
      out_data_nxt.status = ins_status;
      out_data_nxt.slot   = (ins_status == ST_OK) ? 4'(idx_r) : 4'd0;
      out_data_nxt.last   = 1'b1;
    end
    if (cmd.emit_rel) begin
      valid_nxt[addr] = 1'b0;
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - IDX_W'(1);
      end
      out_data_nxt             = '0;
      out_data_nxt.kind        = KIND_RELEASE;
      out_data_nxt.slot        = 4'(idx_r);
      out_data_nxt.out_app_id  = rd_r.app;
      out_data_nxt.out_seq_cnt = rd_r.seq;
      out_data_nxt.out_timeout = rd_r.timeout;
    end
    if (cmd.emit_done) begin
      out_data_nxt      = '0;
      out_data_nxt.kind = KIND_DONE;
      out_data_nxt.last = 1'b1;
    end
    if (cmd.clear_table) begin
      valid_nxt         = '0;
      cnt_nxt           = '0;
      out_data_nxt      = '0;
      out_data_nxt.kind = KIND_STATUS;
      out_data_nxt.last = 1'b1;
    end
    if (cmd.emit_ins || cmd.emit_rel || cmd.emit_done || cmd.clear_table) begin
      out_data_nxt.loaded_count = 5'(cnt_nxt);
      out_data_nxt.full_res     = (cnt_nxt == IDX_W'(SLOTS));
      out_valid_nxt             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      app_lim_r   <= APP_ID_LIMIT_RST;
      time_lim_r  <= TIME_TYPE_LIMIT_RST;
    end else begin
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_APP_ID_LIMIT) begin
        app_lim_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_TIME_TYPE_LIMIT) begin
        time_lim_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* dv/time_tagged_command_scheduler_test.sv */
// ----------------------------------------------------------------------------
// time_tagged_command_scheduler_test
// Self-checking bench for the time-tagged command scheduler.
// ----------------------------------------------------------------------------
// A table of directed requests covers header errors, filling the table, the
// full error, a multi-entry release and a table clear. Random requests then
// run under several limit settings and idling patterns. An internal model of
// the table predicts every result, and results are compared in order.
// ----------------------------------------------------------------------------
module time_tagged_command_scheduler_test;
  import tcs_pkg::*;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 20;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  // Model of the command table.
  logic tbl_valid [SLOTS];
  logic [31:0] tbl_time [SLOTS];
  logic [7:0] tbl_app [SLOTS];
  logic [13:0] tbl_seq [SLOTS];
  logic [15:0] tbl_tmo [SLOTS];
  logic [4:0] tbl_count = '0;
  logic tbl_full = 1'b0;
  logic [7:0] lim_app = APP_ID_LIMIT_RST;
  logic [7:0] lim_tt = TIME_TYPE_LIMIT_RST;

  out_item_t step_results [$];
  out_item_t pending_results [$];
  logic [31:0] time_pool [4];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int req_count = 0;
  int result_count = 0;
  int release_count = 0;
  int full_count = 0;

  time_tagged_command_scheduler #(.SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic out_item_t make_res(input logic [1:0] kind, input logic [3:0] st,
                                         input logic [3:0] slot, input logic [7:0] app,
                                         input logic [13:0] seq, input logic [15:0] tmo,
                                         input logic last);
    return '{kind, st, slot, app, seq, tmo, tbl_count, tbl_full, last};
  endfunction

  function automatic logic [3:0] header_status(input in_item_t it);
    if (it.sub_schedule != 8'd1) return ST_SUB_SCHED;
    if (it.tc_count != 8'd1) return ST_COUNT;
    if (it.interlock_set != 8'd0) return ST_ILK_SET;
    if (it.interlock_assess != 8'd0) return ST_ILK_ASSESS;
    if (it.assess_type != 8'd1) return ST_ASSESS_TYPE;
    if (it.time_type >= lim_tt) return ST_TIME_TYPE;
    if (it.app_id >= lim_app) return ST_APP_ID;
    return ST_OK;
  endfunction

  task automatic schedule_step(input in_item_t it);
    int free_slot;
    logic [3:0] st;
    step_results.delete();
    case (it.func)
      FUNC_INSERT: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) free_slot = i;
        end
        st = header_status(it);
        if (free_slot < 0) begin
          step_results.push_back(make_res(KIND_STATUS, ST_FULL, 4'd0, 8'd0, 14'd0, 16'd0, 1'b1));
        end else if (st != ST_OK) begin
          step_results.push_back(make_res(KIND_STATUS, st, 4'd0, 8'd0, 14'd0, 16'd0, 1'b1));
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_time[free_slot] = it.due_time;
          tbl_tmo[free_slot] = it.run_timeout;
          tbl_app[free_slot] = it.app_id;
          tbl_seq[free_slot] = it.seq_cnt;
          tbl_count = tbl_count + 5'd1;
          if (tbl_count >= SLOTS) tbl_full = 1'b1;
          step_results.push_back(make_res(KIND_STATUS, ST_OK, 4'(free_slot), 8'd0, 14'd0,
                                          16'd0, 1'b1));
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_time[i] == it.current_time) begin
            tbl_valid[i] = 1'b0;
            if (tbl_count > 0) tbl_count = tbl_count - 5'd1;
            tbl_full = 1'b0;
            step_results.push_back(make_res(KIND_RELEASE, ST_OK, 4'(i), tbl_app[i], tbl_seq[i],
                                            tbl_tmo[i], 1'b0));
          end
        end
        step_results.push_back(make_res(KIND_DONE, ST_OK, 4'd0, 8'd0, 14'd0, 16'd0, 1'b1));
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_count = '0;
        tbl_full = 1'b0;
        step_results.push_back(make_res(KIND_STATUS, ST_OK, 4'd0, 8'd0, 14'd0, 16'd0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_req(input in_item_t it, input bit typed, input out_item_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
    schedule_step(it);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] app, input logic [7:0] tt);
    cfg_we <= 1'b1;
    cfg_index <= CFG_APP_ID_LIMIT;
    cfg_data <= app;
    @(posedge clk);
    cfg_index <= CFG_TIME_TYPE_LIMIT;
    cfg_data <= tt;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_app = app;
    lim_tt = tt;
  endtask

  function automatic in_item_t good_insert(input logic [31:0] rel, input logic [15:0] tmo,
                                           input logic [7:0] app, input logic [13:0] seq);
    in_item_t it;
    it = '0;
    it.func = FUNC_INSERT;
    it.sub_schedule = 8'd1;
    it.tc_count = 8'd1;
    it.assess_type = 8'd1;
    it.due_time = rel;
    it.run_timeout = tmo;
    it.app_id = app;
    it.seq_cnt = seq;
    return it;
  endfunction

  // Breaks the header field at position first and every one after it, so the
  // reported status shows which check wins.
  function automatic in_item_t bad_header(input int first);
    in_item_t it;
    it = good_insert(32'hFFFF_FFFF, 16'hFFFF, 8'd1, 14'h3FFF);
    if (first <= 0) it.sub_schedule = 8'd0;
    if (first <= 1) it.tc_count = 8'hFF;
    if (first <= 2) it.interlock_set = 8'd1;
    if (first <= 3) it.interlock_assess = 8'hFF;
    if (first <= 4) it.assess_type = 8'd0;
    if (first <= 5) it.time_type = TIME_TYPE_LIMIT_RST;
    if (first <= 6) it.app_id = APP_ID_LIMIT_RST;
    return it;
  endfunction

  function automatic logic [7:0] pick_code(input logic [7:0] limit);
    if (limit == 8'd0 || $urandom_range(99) < 15) return 8'($urandom);
    return 8'($urandom_range(limit - 1));
  endfunction

  function automatic in_item_t next_req();
    logic [159:0] noise;
    in_item_t it;
    int pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = in_item_t'(noise[$bits(in_item_t)-1:0]);
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.func = FUNC_INSERT;
      it.sub_schedule = 8'd1;
      it.tc_count = 8'd1;
      it.interlock_set = 8'd0;
      it.interlock_assess = 8'd0;
      it.assess_type = 8'd1;
      it.time_type = pick_code(lim_tt);
      it.app_id = pick_code(lim_app);
      if ($urandom_range(99) < 85) it.due_time = time_pool[$urandom_range(3)];
      if (pick >= 50) begin
        case ($urandom_range(4))
          0: it.sub_schedule = 8'($urandom);
          1: it.tc_count = 8'($urandom);
          2: it.interlock_set = 8'($urandom);
          3: it.interlock_assess = 8'($urandom);
          default: it.assess_type = 8'($urandom);
        endcase
      end
    end else if (pick < 85) begin
      it.func = FUNC_TICK;
      if ($urandom_range(99) < 70) it.current_time = time_pool[$urandom_range(3)];
    end else if (pick < 90) begin
      it.func = FUNC_CLEAR;
    end else if (pick < 95) begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  task automatic run_phase(input int n, input int sidle, input int rstall,
                           input logic [7:0] app, input logic [7:0] tt);
    drain();
    set_limits(app, tt);
    send_idle_pct = sidle;
    stall_pct = rstall;
    foreach (time_pool[i]) time_pool[i] = $urandom;
    if ($urandom_range(1)) time_pool[0] = 32'hFFFF_FFFF;
    else time_pool[0] = 32'h0;
    repeat (n) send_req(next_req(), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (out_data.kind == KIND_RELEASE) release_count++;
      if (out_data.kind == KIND_STATUS && out_data.status == ST_FULL) full_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none got %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("slot", 32'(want.slot), 32'(out_data.slot));
        check_field("out_app_id", 32'(want.out_app_id), 32'(out_data.out_app_id));
        check_field("out_seq_cnt", 32'(want.out_seq_cnt), 32'(out_data.out_seq_cnt));
        check_field("out_timeout", 32'(want.out_timeout), 32'(out_data.out_timeout));
        check_field("loaded_count", 32'(want.loaded_count), 32'(out_data.loaded_count));
        check_field("full_res", 32'(want.full_res), 32'(out_data.full_res));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_item_t dir_req [$];
    bit dir_typed [$];
    out_item_t dir_want [$];
    in_item_t it;
    logic [3:0] hdr_codes [7];
    hdr_codes = '{ST_SUB_SCHED, ST_COUNT, ST_ILK_SET, ST_ILK_ASSESS, ST_ASSESS_TYPE,
                  ST_TIME_TYPE, ST_APP_ID};
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;

    it = bad_header(0);
    it.func = FUNC_UNUSED;
    dir_req.push_back(it); dir_typed.push_back(1'b0); dir_want.push_back('0);
    for (int f = 0; f < 7; f++) begin
      dir_req.push_back(bad_header(f));
      dir_typed.push_back(1'b1);
      dir_want.push_back('{KIND_STATUS, hdr_codes[f], 4'd0, 8'd0, 14'd0, 16'd0, 5'd0, 1'b0,
                           1'b1});
    end
    it = good_insert(32'hFFFF_FFFF, 16'hFFFF, 8'd254, 14'h3FFF);
    it.time_type = 8'd2;
    it.current_time = 32'hFFFF_FFFF;
    dir_req.push_back(it);
    dir_typed.push_back(1'b1);
    dir_want.push_back('{KIND_STATUS, ST_OK, 4'd0, 8'd0, 14'd0, 16'd0, 5'd1, 1'b0, 1'b1});
    for (int i = 0; i < SLOTS - 1; i++) begin
      it = good_insert((i % 2) ? 32'hFFFF_FFFF : $urandom, 16'($urandom),
                       (i == 0) ? 8'd0 : 8'($urandom_range(254)), 14'($urandom));
      dir_req.push_back(it); dir_typed.push_back(1'b0); dir_want.push_back('0);
    end
    dir_req.push_back(bad_header(0));
    dir_typed.push_back(1'b1);
    dir_want.push_back('{KIND_STATUS, ST_FULL, 4'd0, 8'd0, 14'd0, 16'd0, 5'd16, 1'b1, 1'b1});
    it = '0;
    it.func = FUNC_TICK;
    it.current_time = 32'hFFFF_FFFF;
    dir_req.push_back(it); dir_typed.push_back(1'b0); dir_want.push_back('0);
    it = '0;
    it.func = FUNC_CLEAR;
    dir_req.push_back(it);
    dir_typed.push_back(1'b1);
    dir_want.push_back('{KIND_STATUS, ST_OK, 4'd0, 8'd0, 14'd0, 16'd0, 5'd0, 1'b0, 1'b1});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_req[i]) send_req(dir_req[i], dir_typed[i], dir_want[i]);

    run_phase(100, 0, 0, 8'd255, 8'd255);
    run_phase(35, 70, 0, 8'd0, 8'd0);
    run_phase(110, 0, 70, 8'd1, 8'd1);
    run_phase(108, 38, 38, 8'($urandom_range(254, 2)), 8'($urandom_range(16, 1)));
    drain();

    $display("Covered %0d requests under five limit and idling settings.", req_count);
    $display("Checked %0d results, %0d releases and %0d refusals on a full table.",
             result_count, release_count, full_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
